FILE: rtl/kpwc_pkg.sv
// ============================================================================
// kpwc_pkg
// Shared types, constants and base-code table for the k-mer pair window
// counter: item and result payloads, controller commands and status.
// ============================================================================
package kpwc_pkg;

    // Default sizing, handed to the top level parameters
    localparam int DEF_MAX_K      = 4;
    localparam int DEF_MAX_N      = 16;
    localparam int DEF_COUNT_BITS = 32;

    // Configuration register reset values
    localparam logic [2:0] KMER_LENGTH_RESET  = 3'd3;
    localparam logic [4:0] MAX_DISTANCE_RESET = 5'd5;

    // Configuration register indexes (paddr[2])
    localparam logic REG_KMER_LENGTH  = 1'b0;
    localparam logic REG_MAX_DISTANCE = 1'b1;

    // Operation codes
    localparam logic OP_FEED = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Base code table: bit 2 flags an invalid code, bits 1:0 carry the base value
    localparam logic [2:0] BASE_LUT [16] = '{
        3'b100, 3'b000, 3'b001, 3'b100, 3'b010, 3'b100, 3'b100, 3'b100,
        3'b011, 3'b100, 3'b100, 3'b100, 3'b100, 3'b100, 3'b100, 3'b100
    };

    typedef struct packed {
        logic       operation;
        logic [7:0] base_code;
        logic       seq_first;
        logic [7:0] row_kmer;
        logic [7:0] col_kmer;
    } in_t;

    typedef struct packed {
        logic [31:0] pair_count;
        logic [4:0]  pairs_added;
    } out_t;

    // Controller to datapath
    typedef struct packed {
        logic clear;    // one step of the count store clearing pass
        logic load;     // take the input item
        logic issue;    // issue one pair step
        logic rd;       // issue the count read
        logic finish;   // deliver the result, commit history
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clr_last;
        logic steps_zero;
    } sts_t;

endpackage

FILE: rtl/kmer_pair_window_counter.sv
// ============================================================================
// kmer_pair_window_counter
// Counts co-occurring k-mer pairs within a sliding distance over a stream of
// DNA bases, with an APB register port and a count read operation.
// ============================================================================
// After reset the block clears its count store, one entry per cycle, over all
// 4^(2*MAX_K) entries (65536 at the default MAX_K of 4); busy stays high until
// the pass ends, while register writes are taken as ever. An item is taken
// when start is high and busy is low. A count read passes through a read
// state, which registers the stored count, and a done state, which registers
// the result and done. A base feed, when the new k-mer completes and the base
// does not start a sequence, issues one pair step per history distance up to
// n (n = effective max_distance) before the done state, else goes straight to
// it; each distance is one read-modify-write step through the count store's
// one read port and one write port. The result is on the result port with done
// high for exactly one cycle, and done cannot be held off; the next item may
// be started in the cycle that result is shown.
module kmer_pair_window_counter #(
    parameter int MAX_K      = kpwc_pkg::DEF_MAX_K,
    parameter int MAX_N      = kpwc_pkg::DEF_MAX_N,
    parameter int COUNT_BITS = kpwc_pkg::DEF_COUNT_BITS
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  kpwc_pkg::in_t   item,
    output logic            done,
    output kpwc_pkg::out_t  result,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [2:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);
    import kpwc_pkg::*;

    logic [2:0] kmer_length_reg;
    logic [4:0] max_distance_reg;
    logic       cfg_wr;
    cmd_t       cmd;
    sts_t       sts;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kmer_length_reg  <= KMER_LENGTH_RESET;
            max_distance_reg <= MAX_DISTANCE_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_KMER_LENGTH:  kmer_length_reg  <= pwdata[2:0];
                REG_MAX_DISTANCE: max_distance_reg <= pwdata[4:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_KMER_LENGTH:  prdata = {29'd0, kmer_length_reg};
            REG_MAX_DISTANCE: prdata = {27'd0, max_distance_reg};
            default:          prdata = '0;
        endcase
    end

    kpwc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (item.operation),
        .busy      (busy),
        .cmd       (cmd),
        .sts       (sts)
    );

    kpwc_dp #(
        .MAX_K      (MAX_K),
        .MAX_N      (MAX_N),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .item         (item),
        .kmer_length  (kmer_length_reg),
        .max_distance (max_distance_reg),
        .result       (result),
        .done         (done)
    );

endmodule

FILE: rtl/kpwc_ctrl.sv
// ============================================================================
// kpwc_ctrl
// Sequencer for the k-mer pair window counter: clearing pass after reset,
// item intake, pair update loop, count read and result delivery.
// ============================================================================
module kpwc_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic           operation,
    output logic           busy,
    output kpwc_pkg::cmd_t cmd,
    input  kpwc_pkg::sts_t sts
);
    import kpwc_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_LOOP  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = (operation == OP_READ) ? S_READ : S_LOOP;
                end
            end
            S_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = S_DONE;
            end
            S_LOOP:
            begin
                // the last issued step completes in the cycle that sees zero
                if (sts.steps_zero)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.issue = 1'b1;
                end
            end
            S_DONE:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

FILE: rtl/kpwc_dp.sv
// ============================================================================
// kpwc_dp
// Datapath of the k-mer pair window counter: base decode, rolling k-mer,
// history ring, count store with a one-step read-modify-write pipeline.
// ============================================================================
module kpwc_dp #(
    parameter int MAX_K      = kpwc_pkg::DEF_MAX_K,
    parameter int MAX_N      = kpwc_pkg::DEF_MAX_N,
    parameter int COUNT_BITS = kpwc_pkg::DEF_COUNT_BITS
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  kpwc_pkg::cmd_t cmd,
    output kpwc_pkg::sts_t sts,
    input  kpwc_pkg::in_t  item,
    input  logic [2:0]     kmer_length,
    input  logic [4:0]     max_distance,
    output kpwc_pkg::out_t result,
    output logic           done
);
    import kpwc_pkg::*;

    localparam int KB    = 2 * MAX_K;                       // bits of one k-mer index
    localparam int AW    = 2 * KB;                          // count store address bits
    localparam int DEPTH = 1 << AW;
    localparam int PW    = (MAX_N > 1) ? $clog2(MAX_N) : 1;
    localparam int NCW   = $clog2(MAX_N + 1);
    localparam int RW    = $clog2(MAX_K + 1);
    localparam int DW    = (NCW > 5) ? NCW : 5;

    // Count store
    logic [COUNT_BITS-1:0] count_mem [DEPTH];
    logic [COUNT_BITS-1:0] rdata_reg;
    logic [AW-1:0]         raddr;
    logic [AW-1:0]         waddr;
    logic [COUNT_BITS-1:0] wdata;
    logic                  we;

    // Base and k-mer state
    logic [KB-1:0]  win_reg;
    logic [RW-1:0]  run_reg;
    logic [KB-1:0]  hist_idx_reg [MAX_N];
    logic [MAX_N-1:0] hist_valid_reg;
    logic [PW-1:0]  ptr_reg;

    // Per-item registers
    logic           op_reg;
    logic           new_valid_reg;
    logic [KB-1:0]  new_idx_reg;
    logic [AW-1:0]  rd_addr_reg;
    logic [PW-1:0]  slot_reg;
    logic [NCW-1:0] remaining_reg;
    logic [NCW-1:0] added_reg;

    // Read-modify-write pipeline
    logic                  p1_valid_reg;
    logic [AW-1:0]         p1_addr_reg;
    logic                  lastw_valid_reg;
    logic [AW-1:0]         lastw_addr_reg;
    logic [COUNT_BITS-1:0] lastw_data_reg;
    logic [AW-1:0]         clr_cnt_reg;

    out_t result_reg;
    logic done_reg;

    // Intake logic
    logic [2:0]     lut;
    logic           base_ok;
    logic [2:0]     eff_k;
    logic [DW-1:0]  md_ext;
    logic [NCW-1:0] eff_n;
    logic [RW-1:0]  run_base;
    logic [RW-1:0]  run_next;
    logic [KB-1:0]  win_next;
    logic           new_valid;
    logic [KB-1:0]  new_idx;
    logic [KB+7:0]  row_ext;
    logic [KB+7:0]  col_ext;

    // Update logic
    logic                  issue_hit;
    logic [COUNT_BITS-1:0] cur_count;
    logic                  pair_we;
    logic [COUNT_BITS+31:0] cnt_ext;
    logic [NCW+4:0]        added_ext;

    always_comb
    begin
        lut     = (item.base_code[7:4] == 4'd0) ? BASE_LUT[item.base_code[3:0]] : 3'b100;
        base_ok = !lut[2];

        priority if (kmer_length < 3'd2)
            eff_k = 3'd2;
        else if (kmer_length > 3'(MAX_K))
            eff_k = 3'(MAX_K);
        else
            eff_k = kmer_length;

        md_ext = DW'(max_distance);
        priority if (md_ext == '0)
            eff_n = NCW'(1);
        else if (md_ext > DW'(MAX_N))
            eff_n = NCW'(MAX_N);
        else
            eff_n = NCW'(md_ext);

        run_base = item.seq_first ? '0 : run_reg;
        if (!base_ok)
            run_next = '0;
        else if (run_base < RW'(MAX_K))
            run_next = run_base + RW'(1);
        else
            run_next = run_base;

        win_next  = base_ok ? {win_reg[KB-3:0], lut[1:0]} : win_reg;
        new_valid = base_ok && (4'(run_next) >= {1'b0, eff_k});
        for (int i = 0; i < KB; i++)
        begin
            new_idx[i] = win_next[i] && (i < 2 * int'(eff_k));
        end

        row_ext = {{KB{1'b0}}, item.row_kmer};
        col_ext = {{KB{1'b0}}, item.col_kmer};
    end

    // Read port address and the update step with one-deep write forwarding
    always_comb
    begin
        issue_hit = cmd.issue && hist_valid_reg[slot_reg];
        raddr     = cmd.rd ? rd_addr_reg : {hist_idx_reg[slot_reg], new_idx_reg};

        if (lastw_valid_reg && (lastw_addr_reg == p1_addr_reg))
            cur_count = lastw_data_reg;
        else
            cur_count = rdata_reg;
        pair_we = p1_valid_reg && !(&cur_count);

        if (cmd.clear)
        begin
            we    = 1'b1;
            waddr = clr_cnt_reg;
            wdata = '0;
        end
        else
        begin
            we    = pair_we;
            waddr = p1_addr_reg;
            wdata = cur_count + COUNT_BITS'(1);
        end

        cnt_ext   = {32'd0, rdata_reg};
        added_ext = {5'd0, added_reg};
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            count_mem[waddr] <= wdata;
        end
        rdata_reg <= count_mem[raddr];
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg         <= '0;
            run_reg         <= '0;
            hist_valid_reg  <= '0;
            ptr_reg         <= '0;
            op_reg          <= OP_FEED;
            remaining_reg   <= '0;
            added_reg       <= '0;
            p1_valid_reg    <= 1'b0;
            lastw_valid_reg <= 1'b0;
            clr_cnt_reg     <= '0;
            done_reg        <= 1'b0;
        end
        else
        begin
            p1_valid_reg    <= issue_hit;
            lastw_valid_reg <= we;
            done_reg        <= cmd.finish;

            if (cmd.clear)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end

            if (cmd.load)
            begin
                op_reg    <= item.operation;
                added_reg <= '0;
                if (item.operation == OP_FEED)
                begin
                    win_reg <= win_next;
                    run_reg <= run_next;
                    if (item.seq_first)
                    begin
                        hist_valid_reg <= '0;
                    end
                    remaining_reg <= (new_valid && !item.seq_first) ? eff_n : '0;
                end
                else
                begin
                    remaining_reg <= '0;
                end
            end

            if (cmd.issue)
            begin
                remaining_reg <= remaining_reg - NCW'(1);
            end

            if (pair_we)
            begin
                added_reg <= added_reg + NCW'(1);
            end

            // commit the new k-mer to the ring after its pairs are counted
            if (cmd.finish && (op_reg == OP_FEED))
            begin
                hist_valid_reg[ptr_reg] <= new_valid_reg;
                ptr_reg <= (ptr_reg == PW'(MAX_N - 1)) ? '0 : ptr_reg + PW'(1);
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        lastw_addr_reg <= waddr;
        lastw_data_reg <= wdata;
        p1_addr_reg    <= raddr;

        if (cmd.load)
        begin
            new_valid_reg <= new_valid;
            new_idx_reg   <= new_idx;
            rd_addr_reg   <= {row_ext[KB-1:0], col_ext[KB-1:0]};
            // walk the ring backward from the newest entry
            slot_reg      <= (ptr_reg == '0) ? PW'(MAX_N - 1) : ptr_reg - PW'(1);
        end
        else if (cmd.issue)
        begin
            slot_reg <= (slot_reg == '0) ? PW'(MAX_N - 1) : slot_reg - PW'(1);
        end

        if (cmd.finish)
        begin
            if (op_reg == OP_FEED)
            begin
                hist_idx_reg[ptr_reg]  <= new_idx_reg;
                result_reg.pair_count  <= '0;
                result_reg.pairs_added <= added_ext[4:0];
            end
            else
            begin
                result_reg.pair_count  <= cnt_ext[31:0];
                result_reg.pairs_added <= '0;
            end
        end
    end

    assign sts.clr_last   = (clr_cnt_reg == '1);
    assign sts.steps_zero = (remaining_reg == '0);
    assign result         = result_reg;
    assign done           = done_reg;

endmodule
